// ===== hw/rtl/crsd_pkg.sv =====
// shared types and constants for the compact record stream decoder
// no dependencies
`default_nettype none

package crsd_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned LEN_W   = 5;
  localparam int unsigned CNT_W   = 8;
  localparam int unsigned MAX_NUM_LEN = 4;

  // result kind codes
  typedef enum logic [2:0] {
    KIND_UNSIGNED = 3'd0,
    KIND_SIGNED   = 3'd1,
    KIND_CHAR     = 3'd2,
    KIND_EMPTY    = 3'd3,
    KIND_COUNT    = 3'd4
  } kind_t;

  // field type codes from header bits 6:5
  typedef enum logic [1:0] {
    FT_UNSIGNED = 2'd0,
    FT_SIGNED   = 2'd1,
    FT_STRING   = 2'd2,
    FT_RESERVED = 2'd3
  } ftype_t;

  // one pending result between front and back
  typedef struct packed {
    kind_t              kind;
    logic [VALUE_W-1:0] value;
    logic [LEN_W-1:0]   length;
    logic               field_done;
    logic               record_done;
    logic               stream_done;
    logic               format_error;
  } crsd_entry_t;

endpackage

`default_nettype wire

// ===== hw/rtl/crsd_if.sv =====
// valid/ready channel interfaces for input bytes and result words
// depends on crsd_pkg
`default_nettype none

interface crsd_in_if
  import crsd_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface crsd_out_if
  import crsd_pkg::*;
();
  logic               valid;
  logic               ready;
  kind_t              kind;
  logic [VALUE_W-1:0] value;
  logic               field_done;
  logic               record_done;
  logic               stream_done;
  logic               format_error;

  modport source (output valid, output kind, output value, output field_done,
                  output record_done, output stream_done, output format_error,
                  input ready);
  modport sink   (input valid, input kind, input value, input field_done,
                  input record_done, input stream_done, input format_error,
                  output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/crsd_front.sv =====
// front end: accepts stream bytes, tracks parse state, classifies results
// depends on crsd_pkg and crsd_in_if
`default_nettype none

module crsd_front
  import crsd_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  crsd_in_if.sink     in_ch,
  input  wire logic   q_full,
  output logic        push,
  output crsd_entry_t push_entry
);

  typedef enum logic [2:0] {
    PH_COUNT   = 3'b001,
    PH_HEADER  = 3'b010,
    PH_PAYLOAD = 3'b100
  } phase_t;

  typedef struct packed {
    logic [CNT_W-1:0] rl;
    logic             sd;
  } close_t;

  phase_t             phase_r, phase_nxt;
  logic [CNT_W-1:0]   records_left_r, records_left_nxt;
  logic [LEN_W-1:0]   bytes_left_r, bytes_left_nxt;
  logic [LEN_W-1:0]   field_length_r, field_length_nxt;
  ftype_t             field_type_r, field_type_nxt;
  logic               last_r, last_nxt;
  logic [VALUE_W-1:0] acc_r, acc_nxt;

  logic              accept;
  logic              emit;
  logic [BYTE_W-1:0] b;
  ftype_t            hdr_type;
  logic [LEN_W-1:0]  hdr_len;
  logic [LEN_W-1:0]  bl_dec;
  close_t            cl;

  function automatic close_t close_f(input logic lst, input logic [CNT_W-1:0] rl);
    close_t c;
    c.rl = rl;
    c.sd = 1'b0;
    if (lst) begin
      c.rl = rl - CNT_W'(1);
      c.sd = (c.rl == '0);
    end
    return c;
  endfunction

  function automatic logic numeric_bad(input ftype_t ft, input logic [LEN_W-1:0] len);
    return (ft == FT_RESERVED) || (len == '0) || (len > LEN_W'(MAX_NUM_LEN));
  endfunction

  function automatic kind_t numeric_kind(input ftype_t ft);
    return (ft == FT_SIGNED) ? KIND_SIGNED : KIND_UNSIGNED;
  endfunction

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.in_byte;
  assign hdr_type    = ftype_t'(b[6:5]);
  assign hdr_len     = b[4:0];
  assign bl_dec      = bytes_left_r - LEN_W'(1);
  assign push        = accept && emit;

  always_comb begin
    phase_nxt        = phase_r;
    records_left_nxt = records_left_r;
    bytes_left_nxt   = bytes_left_r;
    field_length_nxt = field_length_r;
    field_type_nxt   = field_type_r;
    last_nxt         = last_r;
    acc_nxt          = acc_r;
    emit             = 1'b0;
    cl               = close_f(last_r, records_left_r);

    push_entry.kind         = KIND_UNSIGNED;
    push_entry.value        = '0;
    push_entry.length       = field_length_r;
    push_entry.field_done   = 1'b0;
    push_entry.record_done  = 1'b0;
    push_entry.stream_done  = 1'b0;
    push_entry.format_error = 1'b0;

    case (phase_r)
      PH_HEADER: begin
        field_type_nxt   = hdr_type;
        field_length_nxt = hdr_len;
        last_nxt         = b[7];
        bytes_left_nxt   = hdr_len;
        acc_nxt          = '0;
        if (hdr_len == '0) begin
          emit                    = 1'b1;
          cl                      = close_f(b[7], records_left_r);
          records_left_nxt        = cl.rl;
          phase_nxt               = cl.sd ? PH_COUNT : PH_HEADER;
          push_entry.kind         = (hdr_type == FT_STRING) ? KIND_EMPTY
                                                            : numeric_kind(hdr_type);
          push_entry.length       = hdr_len;
          push_entry.field_done   = 1'b1;
          push_entry.record_done  = b[7];
          push_entry.stream_done  = cl.sd;
          push_entry.format_error = (hdr_type != FT_STRING);
        end else begin
          phase_nxt = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        bytes_left_nxt = bl_dec;
        if (field_type_r == FT_STRING) begin
          emit             = 1'b1;
          push_entry.kind  = KIND_CHAR;
          push_entry.value = VALUE_W'(b);
          if (bl_dec == '0) begin
            records_left_nxt       = cl.rl;
            phase_nxt              = cl.sd ? PH_COUNT : PH_HEADER;
            push_entry.field_done  = 1'b1;
            push_entry.record_done = last_r;
            push_entry.stream_done = cl.sd;
          end
        end else begin
          acc_nxt = {acc_r[VALUE_W-BYTE_W-1:0], b};
          if (bl_dec == '0) begin
            emit                    = 1'b1;
            records_left_nxt        = cl.rl;
            phase_nxt               = cl.sd ? PH_COUNT : PH_HEADER;
            push_entry.kind         = numeric_kind(field_type_r);
            push_entry.value        = acc_nxt;
            push_entry.field_done   = 1'b1;
            push_entry.record_done  = last_r;
            push_entry.stream_done  = cl.sd;
            push_entry.format_error = numeric_bad(field_type_r, field_length_r);
          end
        end
      end
      default: begin
        // count byte
        emit                   = 1'b1;
        records_left_nxt       = b;
        phase_nxt              = (b == '0) ? PH_COUNT : PH_HEADER;
        push_entry.kind        = KIND_COUNT;
        push_entry.value       = VALUE_W'(b);
        push_entry.stream_done = (b == '0);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_COUNT;
      records_left_r <= '0;
      bytes_left_r   <= '0;
      field_length_r <= '0;
      field_type_r   <= FT_UNSIGNED;
      last_r         <= 1'b0;
      acc_r          <= '0;
    end else if (accept) begin
      phase_r        <= phase_nxt;
      records_left_r <= records_left_nxt;
      bytes_left_r   <= bytes_left_nxt;
      field_length_r <= field_length_nxt;
      field_type_r   <= field_type_nxt;
      last_r         <= last_nxt;
      acc_r          <= acc_nxt;
    end
  end

  a_hdr_to_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && phase_r == PH_HEADER && hdr_len != '0) |=> phase_r == PH_PAYLOAD)
    else $error("header with payload did not enter payload phase");

  a_payload_left: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PAYLOAD) |-> bytes_left_r != '0)
    else $error("payload phase with no bytes left");

endmodule

`default_nettype wire

// ===== hw/rtl/crsd_queue.sv =====
// two-entry result queue between front and back
// depends on crsd_pkg
`default_nettype none

module crsd_queue
  import crsd_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire crsd_entry_t  push_entry,
  output logic              full,
  input  wire logic         pop,
  output logic              not_empty,
  output crsd_entry_t       head
);

  localparam int unsigned DEPTH = 2;

  crsd_entry_t mem [DEPTH];
  logic        wr_ptr_r, rd_ptr_r;
  logic [1:0]  count_r, count_nxt;

  assign full      = (count_r == 2'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = mem[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 2'(DEPTH))
    else $error("queue count out of range");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && !not_empty))
    else $error("pop from empty queue");

endmodule

`default_nettype wire

// ===== hw/rtl/crsd_back.sv =====
// back end: sign extension of short signed fields and the result word register
// depends on crsd_pkg and crsd_out_if
`default_nettype none

module crsd_back
  import crsd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_not_empty,
  input  wire crsd_entry_t q_head,
  output logic             pop,
  crsd_out_if.source       out_ch
);

  logic               out_valid_r;
  crsd_entry_t        out_r;
  crsd_entry_t        ext_entry;
  logic [VALUE_W-1:0] ext_value;

  always_comb begin
    ext_value = q_head.value;
    if (q_head.kind == KIND_SIGNED) begin
      case (q_head.length)
        LEN_W'(1): begin
          if (q_head.value[7]) ext_value[VALUE_W-1:8] = '1;
        end
        LEN_W'(2): begin
          if (q_head.value[15]) ext_value[VALUE_W-1:16] = '1;
        end
        LEN_W'(3): begin
          if (q_head.value[23]) ext_value[VALUE_W-1:24] = '1;
        end
        default: ext_value = q_head.value;
      endcase
    end
    ext_entry       = q_head;
    ext_entry.value = ext_value;
  end

  assign pop = q_not_empty && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (pop) begin
      out_r <= ext_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ch.ready) begin
      out_valid_r <= q_not_empty;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.kind         = out_r.kind;
  assign out_ch.value        = out_r.value;
  assign out_ch.field_done   = out_r.field_done;
  assign out_ch.record_done  = out_r.record_done;
  assign out_ch.stream_done  = out_r.stream_done;
  assign out_ch.format_error = out_r.format_error;

endmodule

`default_nettype wire

// ===== hw/rtl/compact_record_stream_decoder_core.sv =====
// top level of the compact record stream decoder: front, queue and back
// depends on crsd_pkg, crsd_if, crsd_front, crsd_queue, crsd_back
//
//  channel  dir  handshake     payload
//  in_ch    in   valid/ready   in_byte[7:0]
//  out_ch   out  valid/ready   kind[2:0] value[31:0] field_done record_done
//                              stream_done format_error
//
// one byte accepted per cycle while the queue is not full, set by the parse state update
// a result word is queued at the edge that takes its byte, then loaded into
// the output register once that register is free, and shown on out_ch from there
// synchronous active-low reset returns the parser to expecting a count byte
// in_ch.ready drops only when the two-entry queue is full
`default_nettype none

module compact_record_stream_decoder_core
  import crsd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  crsd_in_if.sink    in_ch,
  crsd_out_if.source out_ch
);

  logic        push;
  crsd_entry_t push_entry;
  logic        q_full;
  logic        pop;
  logic        q_not_empty;
  crsd_entry_t q_head;

  crsd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  crsd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .not_empty  (q_not_empty),
    .head       (q_head)
  );

  crsd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .pop         (pop),
    .out_ch      (out_ch)
  );

endmodule

`default_nettype wire
